// ===== hw/rtl/sqtc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sqtc_pkg
// Shared types, codes and helper functions of the square tone channel.
// ----------------------------------------------------------------------------
package sqtc_pkg;

  localparam int unsigned FreqW = 11;
  localparam int unsigned TimerW = 14;
  localparam logic [3:0] VolMax = 4'd15;
  localparam logic [6:0] LengthFull = 7'd64;
  localparam logic [3:0] SweepDefault = 4'd8;

  typedef enum logic [2:0] {
    CMD_TICK     = 3'd0,
    CMD_LENGTH   = 3'd1,
    CMD_ENVELOPE = 3'd2,
    CMD_SWEEP    = 3'd3,
    CMD_TRIGGER  = 3'd4,
    CMD_LOAD_LEN = 3'd5
  } cmd_e;

  typedef enum logic [2:0] {
    REG_SWEEP    = 3'd0,
    REG_DUTY     = 3'd1,
    REG_LEN_EN   = 3'd2,
    REG_ENVELOPE = 3'd3,
    REG_FREQ     = 3'd4
  } reg_idx_e;

  typedef struct packed {
    logic [6:0]       sweep_control;
    logic [1:0]       duty_select;
    logic             length_enable;
    logic [7:0]       envelope_control;
    logic [FreqW-1:0] tone_frequency;
  } cfg_t;

  typedef struct packed {
    logic [3:0]       sample_level;
    logic             channel_on;
    logic [FreqW-1:0] current_frequency;
  } result_t;

  localparam logic [7:0] DutyPattern [4] = '{8'h01, 8'h81, 8'h87, 8'h7E};

  // Bit 11 set means the target is above the 11-bit range.
  function automatic logic [FreqW:0] sweep_target(input logic [FreqW-1:0] shadow,
                                                  input logic [2:0] shift,
                                                  input logic negate);
    logic [FreqW:0] ext;
    logic [FreqW:0] offset;
    begin
      ext    = {1'b0, shadow};
      offset = ext >> shift;
      sweep_target = negate ? (ext - offset) : (ext + offset);
    end
  endfunction

  // (2048 - f) * 4 in 14 bits
  function automatic logic [TimerW-1:0] timer_reload(input logic [FreqW-1:0] freq);
    timer_reload = 14'd8192 - {1'b0, freq, 2'b00};
  endfunction

endpackage

// ===== hw/rtl/sqtc_cfg_regs.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sqtc_cfg_regs
// Configuration register file, written through a plain write port.
// ----------------------------------------------------------------------------
module sqtc_cfg_regs (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [2:0]          cfg_index_i,
  input  logic [10:0]         cfg_data_i,
  output sqtc_pkg::cfg_t      cfg_o
);

  sqtc_pkg::cfg_t cfg_d, cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (sqtc_pkg::reg_idx_e'(cfg_index_i))
        sqtc_pkg::REG_SWEEP:    cfg_d.sweep_control    = cfg_data_i[6:0];
        sqtc_pkg::REG_DUTY:     cfg_d.duty_select      = cfg_data_i[1:0];
        sqtc_pkg::REG_LEN_EN:   cfg_d.length_enable    = cfg_data_i[0];
        sqtc_pkg::REG_ENVELOPE: cfg_d.envelope_control = cfg_data_i[7:0];
        sqtc_pkg::REG_FREQ:     cfg_d.tone_frequency   = cfg_data_i;
        default:                cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ===== hw/rtl/sqtc_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sqtc_core
// Channel state and its combinational update for one command item.
// ----------------------------------------------------------------------------
module sqtc_core (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                step_i,
  input  logic [2:0]          cmd_i,
  input  logic [5:0]          len_i,
  input  sqtc_pkg::cfg_t      cfg_i,
  output sqtc_pkg::result_t   result_o
);

  logic        active_d, active_q;
  logic [2:0]  duty_d, duty_q;
  logic [13:0] timer_d, timer_q;
  logic [10:0] freq_d, freq_q;
  logic [10:0] shadow_d, shadow_q;
  logic [3:0]  vol_d, vol_q;
  logic [2:0]  env_cd_d, env_cd_q;
  logic [3:0]  sw_cd_d, sw_cd_q;
  logic        sw_act_d, sw_act_q;
  logic [6:0]  len_d, len_q;

  logic [2:0]  sw_period;
  logic [2:0]  sw_shift;
  logic        sw_negate;
  logic [3:0]  sw_reload;
  logic [2:0]  env_period;
  logic        dac_on;
  logic [11:0] tgt;
  logic [11:0] tgt2;
  logic [11:0] trig_tgt;
  logic [7:0]  pattern;

  assign sw_period  = cfg_i.sweep_control[6:4];
  assign sw_negate  = cfg_i.sweep_control[3];
  assign sw_shift   = cfg_i.sweep_control[2:0];
  assign sw_reload  = (sw_period != 3'd0) ? {1'b0, sw_period} : sqtc_pkg::SweepDefault;
  assign env_period = cfg_i.envelope_control[2:0];
  assign dac_on     = (cfg_i.envelope_control[7:3] != 5'd0);

  assign tgt      = sqtc_pkg::sweep_target(shadow_q, sw_shift, sw_negate);
  assign tgt2     = sqtc_pkg::sweep_target(tgt[10:0], sw_shift, sw_negate);
  assign trig_tgt = sqtc_pkg::sweep_target(cfg_i.tone_frequency, sw_shift, sw_negate);

  always_comb begin
    logic [2:0] env_dec;
    logic [3:0] sw_dec;
    env_dec  = env_cd_q - 3'd1;
    sw_dec   = (sw_cd_q != 4'd0) ? (sw_cd_q - 4'd1) : sw_cd_q;
    active_d = active_q;
    duty_d   = duty_q;
    timer_d  = timer_q;
    freq_d   = freq_q;
    shadow_d = shadow_q;
    vol_d    = vol_q;
    env_cd_d = env_cd_q;
    sw_cd_d  = sw_cd_q;
    sw_act_d = sw_act_q;
    len_d    = len_q;
    case (sqtc_pkg::cmd_e'(cmd_i))
      sqtc_pkg::CMD_TICK: begin
        if (active_q) begin
          if (timer_q == 14'd0) begin
            timer_d = sqtc_pkg::timer_reload(freq_q);
            duty_d  = duty_q + 3'd1;
          end else begin
            timer_d = timer_q - 14'd1;
          end
        end
      end
      sqtc_pkg::CMD_LENGTH: begin
        if (cfg_i.length_enable && len_q != 7'd0) begin
          len_d = len_q - 7'd1;
          if (len_q == 7'd1) begin
            active_d = 1'b0;
          end
        end
      end
      sqtc_pkg::CMD_ENVELOPE: begin
        if (active_q && env_period != 3'd0) begin
          if (env_dec == 3'd0) begin
            env_cd_d = env_period;
            if (cfg_i.envelope_control[3]) begin
              if (vol_q != sqtc_pkg::VolMax) vol_d = vol_q + 4'd1;
            end else if (vol_q != 4'd0) begin
              vol_d = vol_q - 4'd1;
            end
          end else begin
            env_cd_d = env_dec;
          end
        end
      end
      sqtc_pkg::CMD_SWEEP: begin
        if (active_q) begin
          if (sw_dec != 4'd0) begin
            sw_cd_d = sw_dec;
          end else begin
            sw_cd_d = sw_reload;
            if (sw_act_q && sw_period != 3'd0) begin
              if (tgt[11]) begin
                active_d = 1'b0;
              end else if (sw_shift != 3'd0) begin
                shadow_d = tgt[10:0];
                freq_d   = tgt[10:0];
                if (tgt2[11]) active_d = 1'b0;
              end
            end
          end
        end
      end
      sqtc_pkg::CMD_TRIGGER: begin
        if (len_q == 7'd0) len_d = sqtc_pkg::LengthFull;
        active_d = dac_on && !(sw_shift != 3'd0 && trig_tgt[11]);
        freq_d   = cfg_i.tone_frequency;
        timer_d  = sqtc_pkg::timer_reload(cfg_i.tone_frequency);
        duty_d   = 3'd0;
        vol_d    = cfg_i.envelope_control[7:4];
        env_cd_d = env_period;
        shadow_d = cfg_i.tone_frequency;
        sw_cd_d  = sw_reload;
        sw_act_d = (sw_period != 3'd0) || (sw_shift != 3'd0);
      end
      sqtc_pkg::CMD_LOAD_LEN: begin
        len_d = sqtc_pkg::LengthFull - {1'b0, len_i};
      end
      default: begin
        active_d = active_q;
      end
    endcase
  end

  assign pattern = sqtc_pkg::DutyPattern[cfg_i.duty_select];

  always_comb begin
    result_o.sample_level      = (active_d && dac_on && pattern[duty_d]) ? vol_d : 4'd0;
    result_o.channel_on        = active_d;
    result_o.current_frequency = freq_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      duty_q   <= '0;
      timer_q  <= '0;
      freq_q   <= '0;
      shadow_q <= '0;
      vol_q    <= '0;
      env_cd_q <= '0;
      sw_cd_q  <= '0;
      sw_act_q <= 1'b0;
      len_q    <= '0;
    end else if (step_i) begin
      active_q <= active_d;
      duty_q   <= duty_d;
      timer_q  <= timer_d;
      freq_q   <= freq_d;
      shadow_q <= shadow_d;
      vol_q    <= vol_d;
      env_cd_q <= env_cd_d;
      sw_cd_q  <= sw_cd_d;
      sw_act_q <= sw_act_d;
      len_q    <= len_d;
    end
  end

endmodule

// ===== hw/rtl/square_tone_channel_with_sweep.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// square_tone_channel_with_sweep
// Square-wave sound channel with length counter, volume envelope and
// frequency sweep, driven by one command item at a time.
//
//   channel  direction  handshake               payload
//   in       input      in_valid_i/in_ready_o   command_i, length_value_i
//   out      output     out_valid_o/out_ready_i sample_level_o, channel_on_o,
//                                               current_frequency_o
//   cfg      input      cfg_we_i                cfg_index_i, cfg_data_i
//
// One item per cycle while the output is not stalled; an item's result
// passes the input register, then the state update into the result register.
// Reset clears all channel state and configuration; no clearing pass.
// A stalled result holds in the result register while one more item waits
// in the input register; then in_ready_o drops.
// ----------------------------------------------------------------------------
module square_tone_channel_with_sweep (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [2:0]  command_i,
  input  logic [5:0]  length_value_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [3:0]  sample_level_o,
  output logic        channel_on_o,
  output logic [10:0] current_frequency_o,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_index_i,
  input  logic [10:0] cfg_data_i
);

  sqtc_pkg::cfg_t    cfg;
  sqtc_pkg::result_t res_next;
  sqtc_pkg::result_t res_q;

  logic       in_vld_d, in_vld_q;
  logic [2:0] cmd_q;
  logic [5:0] len_q;
  logic       out_vld_d, out_vld_q;
  logic       out_free;
  logic       step;
  logic       in_take;

  assign out_free   = !out_vld_q || out_ready_i;
  assign step       = in_vld_q && out_free;
  assign in_ready_o = !in_vld_q || step;
  assign in_take    = in_valid_i && in_ready_o;

  assign in_vld_d  = in_take ? 1'b1 : (step ? 1'b0 : in_vld_q);
  assign out_vld_d = out_free ? step : out_vld_q;

  sqtc_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  sqtc_core u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (step),
    .cmd_i    (cmd_q),
    .len_i    (len_q),
    .cfg_i    (cfg),
    .result_o (res_next)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      in_vld_q  <= in_vld_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      cmd_q <= command_i;
      len_q <= length_value_i;
    end
    if (step) begin
      res_q <= res_next;
    end
  end

  assign out_valid_o         = out_vld_q;
  assign sample_level_o      = res_q.sample_level;
  assign channel_on_o        = res_q.channel_on;
  assign current_frequency_o = res_q.current_frequency;

endmodule

// ===== test/tone_channel_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tone_channel_checker
// Watches the command, result and register ports of the square tone channel,
// runs its own model of the channel on every accepted item and compares each
// result with the oldest predicted sample, field by field.
// ----------------------------------------------------------------------------
module tone_channel_checker
  import sqtc_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_ready_o,
  input  logic [2:0]  command_i,
  input  logic [5:0]  length_value_i,
  input  logic        out_valid_o,
  input  logic        out_ready_i,
  input  logic [3:0]  sample_level_o,
  input  logic        channel_on_o,
  input  logic [10:0] current_frequency_o,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_index_i,
  input  logic [10:0] cfg_data_i,
  output int          mismatches_o,
  output int          outstanding_o
);

  cfg_t        regs;
  logic        chan_on;
  logic [2:0]  duty_pos;
  logic [13:0] timer_cnt;
  logic [10:0] freq_cur;
  logic [10:0] freq_shadow;
  logic [3:0]  vol;
  logic [2:0]  env_cnt;
  logic [3:0]  swp_cnt;
  logic        swp_en;
  logic [6:0]  len_cnt;

  result_t     predicted_samples [$];
  result_t     next_sample;
  result_t     oldest;

  function automatic logic [13:0] reload_of(input logic [10:0] f);
    logic [11:0] span;
    span = 12'd2048 - {1'b0, f};
    return {span, 2'b00};
  endfunction

  // bit 11 set: result above the 11-bit range
  function automatic logic [11:0] sweep_next(input logic [10:0] shadow,
                                             input logic [6:0] ctl);
    int unsigned delta;
    int unsigned base;
    base  = shadow;
    delta = base >> ctl[2:0];
    return ctl[3] ? 12'(base - delta) : 12'(base + delta);
  endfunction

  function automatic logic duty_high(input logic [1:0] sel, input logic [2:0] step);
    logic [7:0] wave;
    case (sel)
      2'd0:    wave = 8'b0000_0001;
      2'd1:    wave = 8'b1000_0001;
      2'd2:    wave = 8'b1000_0111;
      default: wave = 8'b0111_1110;
    endcase
    return wave[step];
  endfunction

  task automatic advance_channel(input logic [2:0] cmd, input logic [5:0] len,
                                 output result_t res);
    logic [11:0] tgt;
    logic [2:0]  per;
    logic [2:0]  shift;
    per   = regs.sweep_control[6:4];
    shift = regs.sweep_control[2:0];
    case (cmd)
      CMD_TICK: begin
        if (chan_on) begin
          if (timer_cnt == '0) begin
            timer_cnt = reload_of(freq_cur);
            duty_pos  = duty_pos + 3'd1;
          end else begin
            timer_cnt = timer_cnt - 14'd1;
          end
        end
      end
      CMD_LENGTH: begin
        if (regs.length_enable && len_cnt != '0) begin
          len_cnt = len_cnt - 7'd1;
          if (len_cnt == '0) chan_on = 1'b0;
        end
      end
      CMD_ENVELOPE: begin
        if (chan_on && regs.envelope_control[2:0] != '0) begin
          env_cnt = env_cnt - 3'd1;
          if (env_cnt == '0) begin
            env_cnt = regs.envelope_control[2:0];
            if (regs.envelope_control[3]) begin
              if (vol != VolMax) vol = vol + 4'd1;
            end else if (vol != '0) begin
              vol = vol - 4'd1;
            end
          end
        end
      end
      CMD_SWEEP: begin
        if (chan_on) begin
          if (swp_cnt != '0) swp_cnt = swp_cnt - 4'd1;
          if (swp_cnt == '0) begin
            swp_cnt = (per != '0) ? {1'b0, per} : SweepDefault;
            if (swp_en && per != '0) begin
              tgt = sweep_next(freq_shadow, regs.sweep_control);
              if (tgt[11]) begin
                chan_on = 1'b0;
              end else if (shift != '0) begin
                freq_shadow = tgt[10:0];
                freq_cur    = tgt[10:0];
                tgt = sweep_next(freq_shadow, regs.sweep_control);
                if (tgt[11]) chan_on = 1'b0;
              end
            end
          end
        end
      end
      CMD_TRIGGER: begin
        if (len_cnt == '0) len_cnt = LengthFull;
        chan_on     = (regs.envelope_control[7:3] != '0);
        freq_cur    = regs.tone_frequency;
        timer_cnt   = reload_of(freq_cur);
        duty_pos    = '0;
        vol         = regs.envelope_control[7:4];
        env_cnt     = regs.envelope_control[2:0];
        freq_shadow = freq_cur;
        swp_cnt     = (per != '0) ? {1'b0, per} : SweepDefault;
        swp_en      = (per != '0) || (shift != '0);
        if (shift != '0) begin
          tgt = sweep_next(freq_shadow, regs.sweep_control);
          if (tgt[11]) chan_on = 1'b0;
        end
      end
      CMD_LOAD_LEN: begin
        len_cnt = LengthFull - {1'b0, len};
      end
      default: ;
    endcase
    res.sample_level = (chan_on && regs.envelope_control[7:3] != '0 &&
                        duty_high(regs.duty_select, duty_pos)) ? vol : 4'd0;
    res.channel_on        = chan_on;
    res.current_frequency = freq_cur;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      regs        = '0;
      chan_on     = 1'b0;
      duty_pos    = '0;
      timer_cnt   = '0;
      freq_cur    = '0;
      freq_shadow = '0;
      vol         = '0;
      env_cnt     = '0;
      swp_cnt     = '0;
      swp_en      = 1'b0;
      len_cnt     = '0;
      predicted_samples.delete();
      mismatches_o  = 0;
      outstanding_o = 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          REG_SWEEP:    regs.sweep_control    = cfg_data_i[6:0];
          REG_DUTY:     regs.duty_select      = cfg_data_i[1:0];
          REG_LEN_EN:   regs.length_enable    = cfg_data_i[0];
          REG_ENVELOPE: regs.envelope_control = cfg_data_i[7:0];
          REG_FREQ:     regs.tone_frequency   = cfg_data_i;
          default: ;
        endcase
      end
      if (in_valid_i && in_ready_o) begin
        advance_channel(command_i, length_value_i, next_sample);
        predicted_samples.push_back(next_sample);
      end
      if (out_valid_o && out_ready_i) begin
        if (predicted_samples.size() == 0) begin
          $error("unexpected result item: level %0d on %0d freq %0d",
                 sample_level_o, channel_on_o, current_frequency_o);
          mismatches_o++;
        end else begin
          oldest = predicted_samples.pop_front();
          if (sample_level_o !== oldest.sample_level) begin
            $error("sample_level: expected %0d, actual %0d",
                   oldest.sample_level, sample_level_o);
            mismatches_o++;
          end
          if (channel_on_o !== oldest.channel_on) begin
            $error("channel_on: expected %0d, actual %0d",
                   oldest.channel_on, channel_on_o);
            mismatches_o++;
          end
          if (current_frequency_o !== oldest.current_frequency) begin
            $error("current_frequency: expected %0d, actual %0d",
                   oldest.current_frequency, current_frequency_o);
            mismatches_o++;
          end
        end
      end
      outstanding_o = predicted_samples.size();
    end
  end

endmodule

// ===== test/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Stimulus for the square tone channel: a directed pass over every command
// and corner of the channel, then register settings from all-zero to all-max
// with random command streams. Both handshakes stall at random; the checker
// beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_top;
  import sqtc_pkg::*;

  localparam int CycleLimit = 200000;
  localparam int Phases     = 12;
  localparam int PhaseItems = 60;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_ready_o;
  logic [2:0]  command_i;
  logic [5:0]  length_value_i;
  logic        out_valid_o;
  logic        out_ready_i;
  logic [3:0]  sample_level_o;
  logic        channel_on_o;
  logic [10:0] current_frequency_o;
  logic        cfg_we_i;
  logic [2:0]  cfg_index_i;
  logic [10:0] cfg_data_i;

  int   mismatches;
  int   outstanding;
  int   cycle_count = 0;
  logic calm;

  square_tone_channel_with_sweep DUT (.*);

  tone_channel_checker u_checker (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .command_i, .length_value_i,
    .out_valid_o, .out_ready_i, .sample_level_o, .channel_on_o,
    .current_frequency_o, .cfg_we_i, .cfg_index_i, .cfg_data_i,
    .mismatches_o (mismatches),
    .outstanding_o(outstanding)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("status: fail");
      $finish;
    end
  end

  always @(negedge clk_i) begin
    out_ready_i <= calm || ($urandom_range(0, 99) >= 13);
  end

  // called at a falling edge; returns at the falling edge after acceptance
  task automatic send_item(input logic [2:0] cmd, input logic [5:0] len);
    while (!calm && $urandom_range(0, 99) < 13) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i     <= 1'b1;
    command_i      <= cmd;
    length_value_i <= len;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (outstanding != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic write_reg(input reg_idx_e idx, input logic [10:0] data);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(negedge clk_i);
  endtask

  task automatic program_regs(input logic [6:0] swp, input logic [1:0] duty,
                              input logic len_en, input logic [7:0] env,
                              input logic [10:0] freq);
    write_reg(REG_SWEEP, 11'(swp));
    write_reg(REG_DUTY, 11'(duty));
    write_reg(REG_LEN_EN, 11'(len_en));
    write_reg(REG_ENVELOPE, 11'(env));
    write_reg(REG_FREQ, freq);
    cfg_we_i <= 1'b0;
  endtask

  function automatic logic [2:0] pick_command();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 45) return CMD_TICK;
    if (r < 55) return CMD_LENGTH;
    if (r < 65) return CMD_ENVELOPE;
    if (r < 75) return CMD_SWEEP;
    if (r < 83) return CMD_TRIGGER;
    if (r < 93) return CMD_LOAD_LEN;
    return 3'(CMD_LOAD_LEN) + 3'($urandom_range(1, 2));
  endfunction

  initial begin
    rst_ni         = 1'b0;
    in_valid_i     = 1'b0;
    command_i      = CMD_TICK;
    length_value_i = '0;
    out_ready_i    = 1'b0;
    cfg_we_i       = 1'b0;
    cfg_index_i    = REG_SWEEP;
    cfg_data_i     = '0;
    calm           = 1'b0;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // registers at reset: unused codes, clocks while off, trigger with DAC off
    send_item(3'(CMD_LOAD_LEN) + 3'd1, 6'd0);
    send_item(3'(CMD_LOAD_LEN) + 3'd2, 6'd63);
    send_item(CMD_TICK, 6'd0);
    send_item(CMD_ENVELOPE, 6'd0);
    send_item(CMD_SWEEP, 6'd0);
    send_item(CMD_LOAD_LEN, 6'd63);
    send_item(CMD_LENGTH, 6'd0);
    send_item(CMD_TRIGGER, 6'd0);
    drain();

    // fastest timer, volume at top, sweep period zero, length runs out
    program_regs(7'd0, 2'd3, 1'b1, 8'hF9, 11'd2047);
    send_item(CMD_TRIGGER, 6'd0);
    repeat (5) send_item(CMD_TICK, 6'd0);
    send_item(CMD_ENVELOPE, 6'd0);
    send_item(CMD_SWEEP, 6'd0);
    send_item(CMD_LOAD_LEN, 6'd63);
    send_item(CMD_LENGTH, 6'd0);
    send_item(CMD_TICK, 6'd0);
    drain();

    // envelope period zero, then DAC off while on, then sweep overflow
    program_regs(7'h11, 2'd2, 1'b0, 8'hA8, 11'd1000);
    send_item(CMD_TRIGGER, 6'd0);
    send_item(CMD_ENVELOPE, 6'd0);
    drain();
    program_regs(7'h11, 2'd2, 1'b0, 8'h01, 11'd1000);
    send_item(CMD_ENVELOPE, 6'd0);
    send_item(CMD_TICK, 6'd0);
    send_item(CMD_SWEEP, 6'd0);
    drain();

    for (int p = 0; p < Phases; p++) begin
      if (p == 0) begin
        program_regs('0, '0, 1'b0, '0, '0);
      end else if (p == 1) begin
        program_regs('1, '1, 1'b1, '1, '1);
      end else begin
        program_regs(7'($urandom_range(0, 127)), 2'($urandom_range(0, 3)),
                     1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)),
                     ($urandom_range(0, 9) < 6) ? 11'($urandom_range(1984, 2047))
                                                : 11'($urandom_range(0, 2047)));
      end
      calm = (p == 5 || p == 6);
      send_item(CMD_TRIGGER, 6'($urandom_range(0, 63)));
      for (int i = 1; i < PhaseItems; i++) begin
        send_item(pick_command(), ($urandom_range(0, 1) == 0)
                                  ? 6'($urandom_range(0, 63))
                                  : 6'($urandom_range(56, 63)));
      end
      drain();
    end
    calm = 1'b0;

    if (mismatches == 0 && outstanding == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
